>>> design/maze_grid_neighbor_query_assert.svh
// assertion macros shared by the maze grid blocks
`ifndef MAZE_GRID_NEIGHBOR_QUERY_ASSERT_SVH
`define MAZE_GRID_NEIGHBOR_QUERY_ASSERT_SVH

`ifndef SYNTH
// checked on every clock edge outside reset
`define MGNQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every clock edge, reset included
`define MGNQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MGNQ_ASSERT(label, clk, rst, prop, msg)
`define MGNQ_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

>>> design/mgnq_pkg.sv
package mgnq_pkg;

   // item field widths
   localparam int ROW_W  = 6;
   localparam int COL_W  = 6;
   localparam int WALL_W = 2;
   localparam int CMD_W  = 1;

   // reach of the row and column fields
   localparam int ROW_FIELD_LIM = 2 ** ROW_W;
   localparam int COL_FIELD_LIM = 2 ** COL_W;

   // grid size defaults
   localparam int MAX_ROWS_DEF = 64;
   localparam int MAX_COLS_DEF = 64;

   // configuration registers
   localparam int CFG_W     = 7;
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS  = 1'd1;
   localparam logic [CFG_W-1:0]     CFG_RESET = 7'd64;

   // commands
   localparam logic [CMD_W-1:0] CMD_WRITE = 1'd0;
   localparam logic [CMD_W-1:0] CMD_QUERY = 1'd1;

   // wall bits
   localparam int WALL_RIGHT  = 0;
   localparam int WALL_BOTTOM = 1;
   localparam logic [WALL_W-1:0] WALLS_CLOSED = 2'b11;

   // neighbor mask bits, in result order
   localparam int NB_W     = 4;
   localparam int NB_UP    = 0;
   localparam int NB_DOWN  = 1;
   localparam int NB_LEFT  = 2;
   localparam int NB_RIGHT = 3;
   localparam logic [NB_W-1:0] PICK_UP    = NB_W'(1) << NB_UP;
   localparam logic [NB_W-1:0] PICK_DOWN  = NB_W'(1) << NB_DOWN;
   localparam logic [NB_W-1:0] PICK_LEFT  = NB_W'(1) << NB_LEFT;
   localparam logic [NB_W-1:0] PICK_RIGHT = NB_W'(1) << NB_RIGHT;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [WALL_W-1:0] walls;
   } req_type;

   typedef struct packed {
      logic             found;
      logic [ROW_W-1:0] nb_row;
      logic [COL_W-1:0] nb_col;
      logic             last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic clear_step;
      logic take_req;
      logic cap_own;
      logic rd_up;
      logic cap_up;
      logic rd_left;
      logic cap_left;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;
      logic req_query;
      logic req_inside;
      logic out_free;
      logic last_pick;
   } status_type;

endpackage

>>> design/maze_grid_neighbor_query.sv
// a write is done in the cycle it is accepted; a query steps through RD_UP, RD_LEFT, CAP_LEFT
//   and EMIT, or goes straight to EMIT when the cell lies out of range
// throughput: writes 1 per cycle; a query holds the input off until its last item (1..4 items)
//   three reads of the single-port cell memory come first, then one item a cycle while the output is not stalled
// reset: synchronous; a clearing pass over all MAX_ROWS x MAX_COLS cells (4096 by default,
//   rows and columns capped at 64) closes all walls, input stalled until it ends
module maze_grid_neighbor_query #(
   parameter int MAX_ROWS = mgnq_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = mgnq_pkg::MAX_COLS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  mgnq_pkg::req_type              req_data,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output mgnq_pkg::rsp_type              rsp_data,
   // register writes: rows in use, columns in use
   input  logic                           csr_we,
   input  logic [mgnq_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mgnq_pkg::CFG_W-1:0]     csr_wdata
);
   import mgnq_pkg::*;

   // command and status between the sequencer and the datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: clearing sweep, accept, three cell reads, one item per result
   mgnq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: limit registers, cell memory, neighbor mask, output register
   mgnq_dp #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> design/mgnq_ram.sv
module mgnq_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> design/mgnq_dp.sv
`include "maze_grid_neighbor_query_assert.svh"

module mgnq_dp #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  mgnq_pkg::req_type                req_data,
   input  logic                             csr_we,
   input  logic [mgnq_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mgnq_pkg::CFG_W-1:0]       csr_wdata,
   input  mgnq_pkg::cmd_type                cmd,
   output mgnq_pkg::status_type             status,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output mgnq_pkg::rsp_type                rsp_data
);
   import mgnq_pkg::*;

   localparam int ROW_LIM = (MAX_ROWS < ROW_FIELD_LIM) ? MAX_ROWS : ROW_FIELD_LIM;
   localparam int COL_LIM = (MAX_COLS < COL_FIELD_LIM) ? MAX_COLS : COL_FIELD_LIM;
   localparam int DEPTH   = ROW_LIM * COL_LIM;
   localparam int AW      = $clog2(DEPTH);
   localparam logic [AW-1:0]    COLS_A    = AW'(COL_LIM);
   localparam logic [AW-1:0]    LAST_ADDR = AW'(DEPTH - 1);
   localparam logic [CFG_W-1:0] ROW_LIM_C = CFG_W'(ROW_LIM);
   localparam logic [CFG_W-1:0] COL_LIM_C = CFG_W'(COL_LIM);

   function automatic logic [AW-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                               input logic [COL_W-1:0] c);
      return AW'(r) * COLS_A + AW'(c);
   endfunction

   logic [CFG_W-1:0]  rows_ff, rows_in;
   logic [CFG_W-1:0]  cols_ff, cols_in;
   logic [ROW_W-1:0]  row_ff;
   logic [COL_W-1:0]  col_ff;
   logic [WALL_W-1:0] own_ff;
   logic [WALL_W-1:0] up_ff;
   logic [NB_W-1:0]   pend_ff, pend_in;
   logic [AW-1:0]     clr_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff, rsp_in;

   logic [CFG_W-1:0]  nrows, ncols;
   logic              req_inside;
   logic [ROW_W-1:0]  up_row;
   logic [COL_W-1:0]  left_col;
   logic [NB_W-1:0]   mask;
   logic [NB_W-1:0]   pick;
   logic              out_free;

   logic              ram_en, ram_we;
   logic [AW-1:0]     ram_addr;
   logic [WALL_W-1:0] ram_wdata, ram_rdata;

   // rows and columns in effect
   assign nrows = (rows_ff > ROW_LIM_C) ? ROW_LIM_C : rows_ff;
   assign ncols = (cols_ff > COL_LIM_C) ? COL_LIM_C : cols_ff;

   assign req_inside = (CFG_W'(req_data.row) < nrows) && (CFG_W'(req_data.col) < ncols);

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ROWS: rows_in = csr_wdata;
            CSR_COLS: cols_in = csr_wdata;
            default:  ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= CFG_RESET;
         cols_ff <= CFG_RESET;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   assign up_row   = (row_ff == '0) ? row_ff : row_ff - ROW_W'(1);
   assign left_col = (col_ff == '0) ? col_ff : col_ff - COL_W'(1);

   // single memory port: clearing sweep, item write, or one of three reads
   always_comb begin
      ram_en    = 1'b0;
      ram_we    = 1'b0;
      ram_addr  = '0;
      ram_wdata = req_data.walls;
      if (cmd.clear_step) begin
         ram_en    = 1'b1;
         ram_we    = 1'b1;
         ram_addr  = clr_ff;
         ram_wdata = WALLS_CLOSED;
      end else if (cmd.take_req) begin
         ram_en   = req_inside;
         ram_we   = (req_data.command == CMD_WRITE);
         ram_addr = cell_addr(req_data.row, req_data.col);
      end else if (cmd.rd_up) begin
         ram_en   = 1'b1;
         ram_addr = cell_addr(up_row, col_ff);
      end else if (cmd.rd_left) begin
         ram_en   = 1'b1;
         ram_addr = cell_addr(row_ff, left_col);
      end
   end

   mgnq_ram #(
      .WIDTH (WALL_W),
      .DEPTH (DEPTH)
   ) u_cells (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // left cell arrives straight from the memory
   always_comb begin
      mask[NB_UP]    = (row_ff != '0) && !up_ff[WALL_BOTTOM];
      mask[NB_DOWN]  = ((CFG_W'(row_ff) + CFG_W'(1)) < nrows) && !own_ff[WALL_BOTTOM];
      mask[NB_LEFT]  = (col_ff != '0) && !ram_rdata[WALL_RIGHT];
      mask[NB_RIGHT] = ((CFG_W'(col_ff) + CFG_W'(1)) < ncols) && !own_ff[WALL_RIGHT];
   end

   // lowest pending neighbor goes out first
   assign pick     = pend_ff & (~pend_ff + NB_W'(1));
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      pend_in = pend_ff;
      if (cmd.take_req) begin
         pend_in = '0;
      end else if (cmd.cap_left) begin
         pend_in = mask;
      end else if (cmd.emit) begin
         pend_in = pend_ff & ~pick;
      end
   end

   always_comb begin
      rsp_in.found  = (pend_ff != '0);
      rsp_in.last   = ((pend_ff & ~pick) == '0);
      rsp_in.nb_row = '0;
      rsp_in.nb_col = '0;
      case (pick)
         PICK_UP: begin
            rsp_in.nb_row = row_ff - ROW_W'(1);
            rsp_in.nb_col = col_ff;
         end
         PICK_DOWN: begin
            rsp_in.nb_row = row_ff + ROW_W'(1);
            rsp_in.nb_col = col_ff;
         end
         PICK_LEFT: begin
            rsp_in.nb_row = row_ff;
            rsp_in.nb_col = col_ff - COL_W'(1);
         end
         PICK_RIGHT: begin
            rsp_in.nb_row = row_ff;
            rsp_in.nb_col = col_ff + COL_W'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_step && (clr_ff != LAST_ADDR)) begin
            clr_ff <= clr_ff + AW'(1);
         end
         pend_ff <= pend_in;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         row_ff <= req_data.row;
         col_ff <= req_data.col;
      end
      if (cmd.cap_own) begin
         own_ff <= ram_rdata;
      end
      if (cmd.cap_up) begin
         up_ff <= ram_rdata;
      end
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign status.clear_done = (clr_ff == LAST_ADDR);
   assign status.req_query  = (req_data.command == CMD_QUERY);
   assign status.req_inside = req_inside;
   assign status.out_free   = out_free;
   assign status.last_pick  = rsp_in.last;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `MGNQ_ASSERT(a_pend_shrinks, clock, reset, cmd.emit && (pend_ff != '0) |=> $countones(pend_ff) == $past($countones(pend_ff)) - 1, "emit did not retire exactly one neighbor")
   `MGNQ_ASSERT(a_clear_sweep, clock, reset, cmd.clear_step && !status.clear_done |=> clr_ff == $past(clr_ff) + AW'(1), "clearing sweep skipped an entry")
   `MGNQ_ASSERT(a_empty_shape, clock, reset, rsp_valid_ff && !rsp_ff.found |-> rsp_ff.last && (rsp_ff.nb_row == '0) && (rsp_ff.nb_col == '0), "empty result is not a lone zero item")

endmodule

>>> design/mgnq_ctrl.sv
`include "maze_grid_neighbor_query_assert.svh"

module mgnq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  mgnq_pkg::status_type status,
   output mgnq_pkg::cmd_type    cmd
);
   import mgnq_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_UP,
      ST_RD_LEFT,
      ST_CAP_LEFT,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take_req = 1'b1;
               if (status.req_query) begin
                  state_in = status.req_inside ? ST_RD_UP : ST_EMIT;
               end
            end
         end
         ST_RD_UP: begin
            cmd.cap_own = 1'b1;
            cmd.rd_up   = 1'b1;
            state_in    = ST_RD_LEFT;
         end
         ST_RD_LEFT: begin
            cmd.cap_up  = 1'b1;
            cmd.rd_left = 1'b1;
            state_in    = ST_CAP_LEFT;
         end
         ST_CAP_LEFT: begin
            cmd.cap_left = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.last_pick) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   `MGNQ_ASSERT(a_last_to_idle, clock, reset, cmd.emit && status.last_pick |=> state_ff == ST_IDLE, "query did not end on its last item")
   `MGNQ_ASSERT(a_query_entry, clock, reset, state_ff == ST_RD_UP |-> $past(state_ff) == ST_IDLE, "cell reads started outside an accepted query")
   `MGNQ_ASSERT_ALWAYS(a_emit_free, clock, !cmd.emit || status.out_free, "result loaded over a waiting item")

endmodule

>>> verif/maze_grid_neighbor_query_test.sv
`timescale 1ns / 100ps
module maze_grid_neighbor_query_test;
   import mgnq_pkg::*;

   // grid model plus the queue of neighbor items still owed by the block
   class maze_scoreboard;
      logic [WALL_W-1:0] grid [ROW_FIELD_LIM][COL_FIELD_LIM];
      logic [CFG_W-1:0] rows_cfg;
      logic [CFG_W-1:0] cols_cfg;
      rsp_type due_neighbors[$];
      int errors;

      function new();
         foreach (grid[r, c]) grid[r][c] = WALLS_CLOSED;
         rows_cfg = CFG_RESET;
         cols_cfg = CFG_RESET;
         errors = 0;
      endfunction

      function void set_size(logic [CSR_IDX_W-1:0] index, logic [CFG_W-1:0] value);
         if (index == CSR_ROWS) rows_cfg = value;
         else if (index == CSR_COLS) cols_cfg = value;
      endfunction

      function int unsigned span(logic [CFG_W-1:0] value, int unsigned top);
         int unsigned lim;
         lim = int'(value);
         if (lim > top) lim = top;
         return lim;
      endfunction

      function rsp_type hop(int unsigned r, int unsigned c);
         rsp_type entry;
         entry.found = 1'b1;
         entry.nb_row = ROW_W'(r);
         entry.nb_col = COL_W'(c);
         entry.last = 1'b0;
         return entry;
      endfunction

      // apply one accepted item: writes update the grid, queries queue their neighbors
      function void take_request(req_type item);
         int unsigned nrows;
         int unsigned ncols;
         int unsigned r;
         int unsigned c;
         rsp_type hits[$];
         rsp_type none;
         nrows = span(rows_cfg, MAX_ROWS_DEF);
         ncols = span(cols_cfg, MAX_COLS_DEF);
         r = int'(item.row);
         c = int'(item.col);
         if (item.command == CMD_WRITE) begin
            if (r < nrows && c < ncols) grid[r][c] = item.walls;
            return;
         end
         if (r < nrows && c < ncols) begin
            // up and left look at the neighbor's own bottom and right walls
            if (r > 0 && !grid[r-1][c][WALL_BOTTOM]) hits.insert(hits.size(), hop(r - 1, c));
            if (r + 1 < nrows && !grid[r][c][WALL_BOTTOM])
               hits.insert(hits.size(), hop(r + 1, c));
            if (c > 0 && !grid[r][c-1][WALL_RIGHT]) hits.insert(hits.size(), hop(r, c - 1));
            if (c + 1 < ncols && !grid[r][c][WALL_RIGHT])
               hits.insert(hits.size(), hop(r, c + 1));
         end
         if (hits.size() == 0) begin
            // out of range or boxed in: a single empty item
            none = '0;
            none.last = 1'b1;
            due_neighbors.insert(due_neighbors.size(), none);
         end else begin
            hits[hits.size()-1].last = 1'b1;
            foreach (hits[k]) due_neighbors.insert(due_neighbors.size(), hits[k]);
         end
      endfunction

      task report(string what);
         errors++;
         $display("mismatch at %0t: %s", $time, what);
      endtask

      task check_neighbor(rsp_type got);
         rsp_type want;
         if (due_neighbors.size() == 0) begin
            report($sformatf("unexpected item found=%0b row=%0d col=%0d last=%0b",
                             got.found, got.nb_row, got.nb_col, got.last));
            return;
         end
         want = due_neighbors.pop_front();
         if (got.found !== want.found)
            report($sformatf("found %0b, want %0b", got.found, want.found));
         if (got.nb_row !== want.nb_row)
            report($sformatf("nb_row %0d, want %0d", got.nb_row, want.nb_row));
         if (got.nb_col !== want.nb_col)
            report($sformatf("nb_col %0d, want %0d", got.nb_col, want.nb_col));
         if (got.last !== want.last)
            report($sformatf("last %0b, want %0b", got.last, want.last));
      endtask
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_type              rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   maze_scoreboard board;
   // set for the closing stretch: no gaps on either side
   bit calm = 1'b0;

   maze_grid_neighbor_query dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // generous cap: clearing pass plus every item at its slowest, several times over
   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // receiver stalls in short bursts, with the odd long quiet stretch
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 40) == 0) begin
            repeat ($urandom_range(20, 60)) @(posedge clock);
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // every item that leaves the block is checked against the oldest expectation
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         board.check_neighbor(rsp_data);
   end

   // hold the item until the block takes it; valid stays high for the caller
   task automatic send_item(input req_type item);
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      board.take_request(item);
   endtask

   // random sender gap after an accepted item
   task automatic pace();
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // stop sending until every owed item is back, then let a trailing write settle
   task automatic drain();
      req_valid <= 1'b0;
      while (board.due_neighbors.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic send_fields(input logic [CMD_W-1:0] cmd, input int unsigned r,
                              input int unsigned c, input logic [WALL_W-1:0] w);
      req_type item;
      item.command = cmd;
      item.row = ROW_W'(r);
      item.col = COL_W'(c);
      item.walls = w;
      send_item(item);
      pace();
   endtask

   // both size registers in back-to-back cycles; only called with the block idle
   task automatic write_size(input logic [CFG_W-1:0] rows_val,
                             input logic [CFG_W-1:0] cols_val);
      csr_we <= 1'b1;
      csr_index <= CSR_ROWS;
      csr_wdata <= rows_val;
      @(posedge clock);
      board.set_size(CSR_ROWS, rows_val);
      csr_index <= CSR_COLS;
      csr_wdata <= cols_val;
      @(posedge clock);
      board.set_size(CSR_COLS, cols_val);
      csr_we <= 1'b0;
   endtask

   // mostly cells near a working window so writes and queries meet
   function automatic logic [ROW_W-1:0] pick_pos(input int unsigned lim,
                                                 input int unsigned base);
      if (lim == 0 || $urandom_range(0, 9) == 0) return ROW_W'($urandom_range(0, 63));
      if (lim <= 8) return ROW_W'($urandom_range(0, lim - 1));
      return ROW_W'(base + $urandom_range(0, 5));
   endfunction

   task automatic run_phase(input logic [CFG_W-1:0] rows_val,
                            input logic [CFG_W-1:0] cols_val, input int n);
      req_type item;
      int unsigned lr;
      int unsigned lc;
      int unsigned br;
      int unsigned bc;
      drain();
      write_size(rows_val, cols_val);
      lr = (rows_val > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(rows_val);
      lc = (cols_val > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(cols_val);
      br = (lr > 8) ? $urandom_range(0, lr - 6) : 0;
      bc = (lc > 8) ? $urandom_range(0, lc - 6) : 0;
      repeat (n) begin
         item.command = ($urandom_range(0, 1) == 0) ? CMD_WRITE : CMD_QUERY;
         item.row = pick_pos(lr, br);
         item.col = pick_pos(lc, bc);
         item.walls = WALL_W'($urandom_range(0, 3));
         send_item(item);
         pace();
         // now and then wait for the block to empty out mid-phase
         if (!calm && $urandom_range(0, 79) == 0) drain();
      end
   endtask

   initial begin
      board = new();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_we <= 1'b0;
      csr_index <= CSR_ROWS;
      csr_wdata <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed, reset size 64 x 64
      send_fields(CMD_QUERY, 0, 0, 2'd0);      // corner, all walls closed
      send_fields(CMD_WRITE, 5, 5, 2'd0);
      send_fields(CMD_WRITE, 4, 5, 2'd1);      // upper cell bottom open
      send_fields(CMD_WRITE, 5, 4, 2'd2);      // left cell right open
      send_fields(CMD_QUERY, 5, 5, 2'd3);      // all four neighbors
      send_fields(CMD_WRITE, 5, 5, 2'd3);
      send_fields(CMD_QUERY, 5, 5, 2'd0);      // only up and left remain
      send_fields(CMD_WRITE, 0, 0, 2'd0);
      send_fields(CMD_QUERY, 0, 0, 2'd0);      // top and left edges
      send_fields(CMD_WRITE, 63, 63, 2'd0);
      send_fields(CMD_WRITE, 62, 63, 2'd1);
      send_fields(CMD_WRITE, 63, 62, 2'd2);
      send_fields(CMD_QUERY, 63, 63, 2'd0);    // bottom and right edges hold
      send_fields(CMD_WRITE, 63, 0, 2'd0);
      send_fields(CMD_QUERY, 63, 0, 2'd0);
      send_fields(CMD_WRITE, 0, 63, 2'd2);
      send_fields(CMD_QUERY, 0, 63, 2'd0);     // boxed in at the top right

      // directed, small grid: range checks against the size registers
      drain();
      write_size(7'd3, 7'd4);
      send_fields(CMD_QUERY, 3, 0, 2'd0);      // row out of range
      send_fields(CMD_QUERY, 0, 4, 2'd0);      // column out of range
      send_fields(CMD_WRITE, 2, 5, 2'd0);      // ignored
      send_fields(CMD_WRITE, 2, 3, 2'd0);
      send_fields(CMD_WRITE, 1, 3, 2'd0);
      send_fields(CMD_QUERY, 2, 3, 2'd0);      // last row and column of the grid

      // random phases over several sizes, extremes included
      run_phase(7'd8, 7'd8, 140);
      run_phase(7'd64, 7'd64, 90);
      run_phase(7'd127, 7'd2, 50);
      run_phase(7'd1, 7'd1, 30);
      run_phase(7'd0, 7'd64, 20);              // no rows in use
      run_phase(7'($urandom_range(2, 12)), 7'($urandom_range(2, 12)), 60);

      // closing stretch with no gaps on either side
      drain();
      calm = 1'b1;
      run_phase(7'd64, 7'd64, 90);
      drain();

      if (board.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
